/* hw/rtl/grmt_pkg.sv */
package grmt_pkg;

   // table geometry
   localparam int REGIONS        = 16;
   localparam int RANK_W         = 4;
   localparam int COUNT_W        = 5;
   localparam int WRITE_FLAG_BIT = 1;

   // command codes
   localparam logic [2:0] CMD_MAP     = 3'd0;
   localparam logic [2:0] CMD_UNMAP   = 3'd1;
   localparam logic [2:0] CMD_PROTECT = 3'd2;
   localparam logic [2:0] CMD_READ    = 3'd3;
   localparam logic [2:0] CMD_WRITE   = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_ZERO_LEN  = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_DENIED    = 3'd4;

   typedef logic [RANK_W-1:0]  rank_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CMP1,
      S_CMP2,
      S_SEL,
      S_EXEC
   } state_type;

   // command broadcast to every cell
   typedef struct packed {
      logic [2:0]  cmd;
      logic [63:0] guest_addr;
      logic [63:0] host_addr;
      logic [63:0] length;
      logic [31:0] flags;
   } req_type;

   // per-cycle control broadcast to every cell
   typedef struct packed {
      logic     phase1;
      logic     phase2;
      logic     do_map;
      logic     do_unmap;
      logic     do_protect;
      rank_type new_rank;
      rank_type win_rank;
   } ctl_type;

   // status from a cell back to the selector
   typedef struct packed {
      logic        valid;
      rank_type    rank;
      logic        hit;
      logic [63:0] guest_base;
      logic [63:0] host_base;
      logic [31:0] flags;
   } cell_stat_type;

endpackage

/* hw/rtl/grmt_cell.sv */
module grmt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  grmt_pkg::req_type       req,
   input  grmt_pkg::ctl_type       ctl,
   input  logic                    win,
   input  logic                    found_in,
   output logic                    found_out,
   output grmt_pkg::cell_stat_type stat
);
   import grmt_pkg::*;

   logic        valid_ff, valid_in;
   rank_type    rank_ff, rank_in;
   logic [63:0] gb_ff, gb_in;
   logic [63:0] hb_ff, hb_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] fl_ff, fl_in;
   logic        ge_ff, ge_in;
   logic [63:0] off_ff, off_in;
   logic        hitc_ff, hitc_in;
   logic        hitx_ff, hitx_in;
   logic        take;

   // first free slot along the row
   assign take      = !valid_ff && !found_in;
   assign found_out = found_in || !valid_ff;

   // compare pipeline: offset first, then range fit and exact match
   always_comb begin
      ge_in   = ge_ff;
      off_in  = off_ff;
      hitc_in = hitc_ff;
      hitx_in = hitx_ff;
      if (ctl.phase1) begin
         ge_in  = req.guest_addr >= gb_ff;
         off_in = req.guest_addr - gb_ff;
      end
      if (ctl.phase2) begin
         hitc_in = ge_ff && (off_ff <= len_ff) && (req.length <= len_ff - off_ff);
         hitx_in = (gb_ff == req.guest_addr) && (len_ff == req.length);
      end
   end

   // entry updates
   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      gb_in    = gb_ff;
      hb_in    = hb_ff;
      len_in   = len_ff;
      fl_in    = fl_ff;
      if (ctl.do_map && take) begin
         valid_in = 1'b1;
         rank_in  = ctl.new_rank;
         gb_in    = req.guest_addr;
         hb_in    = req.host_addr;
         len_in   = req.length;
         fl_in    = req.flags;
      end
      if (ctl.do_unmap) begin
         if (win) begin
            valid_in = 1'b0;
         end else if (valid_ff && rank_ff > ctl.win_rank) begin
            rank_in = rank_ff - 1'b1;
         end
      end
      if (ctl.do_protect && win) begin
         fl_in = req.flags;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rank_ff <= rank_in;
      gb_ff   <= gb_in;
      hb_ff   <= hb_in;
      len_ff  <= len_in;
      fl_ff   <= fl_in;
      ge_ff   <= ge_in;
      off_ff  <= off_in;
      hitc_ff <= hitc_in;
      hitx_ff <= hitx_in;
   end

   always_comb begin
      stat.valid      = valid_ff;
      stat.rank       = rank_ff;
      stat.hit        = valid_ff && ((req.cmd == CMD_UNMAP) ? hitx_ff : hitc_ff);
      stat.guest_base = gb_ff;
      stat.host_base  = hb_ff;
      stat.flags      = fl_ff;
   end

endmodule

/* hw/rtl/guest_region_map_table_core.sv */
// Guest region map table.
// req_ channel: one command transaction (map, unmap, protect, read check,
// write check). rsp_ channel: exactly one result transaction per command.
// The table is a row of 16 entry cells; each compares the broadcast command
// against its own region, and a free-slot flag ripples along the row so the
// lowest free cell takes a new mapping.
// Each command passes through the compare steps S_CMP1 and S_CMP2, the
// newest-match select S_SEL and the execute step S_EXEC before its result
// is registered at rsp_. One command is in flight at a time, so a new
// command is taken only once the last one has left its execute step.
// The result sits in an output register; if the receiver stalls, the next
// command is still accepted and worked through, and it waits in its execute
// step (table unchanged) until the output register frees up.
// Reset (synchronous, active high) empties the table and the live count and
// drops any pending result; no clearing pass is needed.
module guest_region_map_table_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cmd[2:0], guest_addr[66:3], host_addr[130:67], length[194:131],
   // flags[226:195], zero fill
   input  logic [231:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[2:0], host_address[66:3], region_total[73:67], zero fill
   output logic [79:0]  rsp_tdata
);
   import grmt_pkg::*;

   state_type     state_ff, state_in;
   req_type       req_ff;
   count_type     live_ff, live_in;
   logic [REGIONS-1:0] win_ff, win_in;
   logic          found_ff, found_in;
   rank_type      wrank_ff, wrank_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [79:0]   rsp_data_ff, rsp_data_in;

   ctl_type       ctl;
   cell_stat_type stat [REGIONS];
   logic [REGIONS:0] chain;
   logic          accept, go;
   logic [REGIONS-1:0] rank_hit;
   logic [REGIONS-1:0] valid_vec;
   logic [63:0]   hb_sel, gb_sel;
   logic [31:0]   fl_sel;
   logic [2:0]    status;
   logic [63:0]   haddr;
   logic          map_ok;

   assign accept = req_tvalid && req_tready;
   assign go     = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);

   // command register
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.cmd        <= req_tdata[2:0];
         req_ff.guest_addr <= req_tdata[66:3];
         req_ff.host_addr  <= req_tdata[130:67];
         req_ff.length     <= req_tdata[194:131];
         req_ff.flags      <= req_tdata[226:195];
      end
   end

   // row of entry cells
   assign chain[0] = 1'b0;
   for (genvar i = 0; i < REGIONS; i++) begin : g_cell
      grmt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .req       (req_ff),
         .ctl       (ctl),
         .win       (win_ff[i]),
         .found_in  (chain[i]),
         .found_out (chain[i+1]),
         .stat      (stat[i])
      );
      assign valid_vec[i] = stat[i].valid;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_tvalid) state_in = S_CMP1;
         S_CMP1:  state_in = S_CMP2;
         S_CMP2:  state_in = S_SEL;
         S_SEL:   state_in = S_EXEC;
         S_EXEC:  if (go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // newest match: live ranks are unique, so bucket hits by rank
   always_comb begin
      rank_hit = '0;
      for (int i = 0; i < REGIONS; i++) begin
         if (stat[i].hit) rank_hit[stat[i].rank] = 1'b1;
      end
      found_in = |rank_hit;
      wrank_in = '0;
      for (int r = 0; r < REGIONS; r++) begin
         if (rank_hit[r]) wrank_in = rank_type'(r);
      end
      for (int i = 0; i < REGIONS; i++) begin
         win_in[i] = stat[i].hit && (stat[i].rank == wrank_in);
      end
   end

   // winner fields
   always_comb begin
      hb_sel = '0;
      gb_sel = '0;
      fl_sel = '0;
      for (int i = 0; i < REGIONS; i++) begin
         if (win_ff[i]) begin
            hb_sel = hb_sel | stat[i].host_base;
            gb_sel = gb_sel | stat[i].guest_base;
            fl_sel = fl_sel | stat[i].flags;
         end
      end
   end

   // result of the execute step
   always_comb begin
      status = ST_NOT_FOUND;
      haddr  = '0;
      map_ok = 1'b0;
      case (req_ff.cmd)
         CMD_MAP: begin
            if (req_ff.length == '0) begin
               status = ST_ZERO_LEN;
            end else if (live_ff >= count_type'(REGIONS) || !chain[REGIONS]) begin
               status = ST_FULL;
            end else begin
               status = ST_OK;
               map_ok = 1'b1;
            end
         end
         CMD_UNMAP, CMD_PROTECT: begin
            if (found_ff) status = ST_OK;
         end
         CMD_READ, CMD_WRITE: begin
            if (found_ff) begin
               if (req_ff.cmd == CMD_WRITE && !fl_sel[WRITE_FLAG_BIT]) begin
                  status = ST_DENIED;
               end else begin
                  status = ST_OK;
                  haddr  = hb_sel + (req_ff.guest_addr - gb_sel);
               end
            end
         end
         default: status = ST_NOT_FOUND;
      endcase
   end

   // control outputs
   always_comb begin
      ctl.phase1     = (state_ff == S_CMP1);
      ctl.phase2     = (state_ff == S_CMP2);
      ctl.do_map     = go && map_ok;
      ctl.do_unmap   = go && (req_ff.cmd == CMD_UNMAP) && found_ff;
      ctl.do_protect = go && (req_ff.cmd == CMD_PROTECT) && found_ff;
      ctl.new_rank   = live_ff[RANK_W-1:0];
      ctl.win_rank   = wrank_ff;
      req_tready     = (state_ff == S_IDLE);
      live_in        = live_ff;
      if (ctl.do_map) live_in = live_ff + 1'b1;
      if (ctl.do_unmap) live_in = live_ff - 1'b1;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (go) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, 7'(live_in), haddr, status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      if (state_ff == S_SEL) begin
         win_ff   <= win_in;
         found_ff <= found_in;
         wrank_ff <= wrank_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // live count tracks the valid cells
   a_live_count: assert property (@(posedge clock) disable iff (reset)
      live_ff == count_type'($countones(valid_vec)))
      else $error("live count out of step with valid cells");

   // at most one winner, exactly one when a match was found
   a_one_winner: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |-> (found_ff ? $onehot(win_ff) : (win_ff == '0)))
      else $error("winner select not one-hot");

   // live count only changes in a committed execute step
   a_live_stable: assert property (@(posedge clock) disable iff (reset)
      !go |=> $stable(live_ff))
      else $error("live count changed outside execute");

   // a command is never taken while one is in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("input ready while busy");

endmodule
